// ===== rtl/srmcs_pkg.sv =====
// Shared types, constants and sequencer states for the commutation sequencer.
package srmcs_pkg;

    localparam int MAX_STATES_DEF      = 64;
    localparam int NUM_SWITCHES_DEF    = 8;
    localparam int MAX_BASE_STATES_DEF = 8;

    localparam int POS_W   = 18;   // stored interval bound, signed
    localparam int WIDE_W  = 20;   // unwrapped sum, signed
    localparam int DVD_W   = 20;   // divider dividend
    localparam int DVS_W   = 16;   // divider divisor
    localparam int TOT_W   = 7;    // ring length, at most 8 * 15 before the cap
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSES   = 3'd0,
        REG_STATES   = 3'd1,
        REG_EREV     = 3'd2,
        REG_OFFSET   = 3'd3,
        REG_REVERSE  = 3'd4,
        REG_MASKS    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_BUILD = 2'd1,
        OP_POS   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIDTH,
        ST_GCD,
        ST_ERR,
        ST_PERIOD,
        ST_WRAP,
        ST_STORE,
        ST_CHANGE,
        ST_READ,
        ST_CMP,
        ST_LOAD,
        ST_BASE,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== rtl/srmcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== rtl/srmcs_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module srmcs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  srmcs_pkg::div_req_t req,
    output srmcs_pkg::div_rsp_t rsp
);
    import srmcs_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg, dvs_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end else if (req.start && !done_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule

// ===== rtl/srm_commutation_sequencer.sv =====
// Top level: commutation sequencer for a switched reluctance motor.
// Result path: step, unused op or pre-build position run only the base divide;
//   a position sample first reads and compares the table, loading new bounds
//   when it switches; a build first runs width, Euclid, error and period divides
//   and a wrap, change and store pass per ring state. One transaction at a time;
//   the next is taken in the cycle after the result; divides share one 20-step divider.
// Reset: synchronous active-low aresetn clears control state, index, held
//   bounds and table-ready; the interval table itself is not cleared.
module srm_commutation_sequencer #(
    parameter int MAX_STATES      = srmcs_pkg::MAX_STATES_DEF,
    parameter int NUM_SWITCHES    = srmcs_pkg::NUM_SWITCHES_DEF,
    parameter int MAX_BASE_STATES = srmcs_pkg::MAX_BASE_STATES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [srmcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srmcs_pkg::CFG_W-1:0]       cfg_wr_data,
    // input transactions
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic signed [17:0]                s_position,
    // result transactions
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_switch_mask,
    output logic [5:0]                        m_state_index,
    output logic                              m_switched,
    output logic                              m_table_ready
);
    import srmcs_pkg::*;

    localparam int IW      = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int TCAP    = (MAX_STATES < 127) ? MAX_STATES : 127;
    localparam int ENTRY_W = 2 * POS_W + 1;
    localparam logic [7:0] SW_MASK = 8'((1 << NUM_SWITCHES) - 1);

    // ---------------- configuration registers ----------------
    logic [15:0]        ppr_reg;
    logic [3:0]         spe_reg, epm_reg;
    logic signed [15:0] off_reg;
    logic               rev_reg;
    logic [63:0]        masks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppr_reg   <= 16'd4096;
            spe_reg   <= 4'd3;
            epm_reg   <= 4'd4;
            off_reg   <= '0;
            rev_reg   <= 1'b0;
            masks_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PULSES:  ppr_reg   <= cfg_wr_data[15:0];
                REG_STATES:  spe_reg   <= cfg_wr_data[3:0];
                REG_EREV:    epm_reg   <= cfg_wr_data[3:0];
                REG_OFFSET:  off_reg   <= cfg_wr_data[15:0];
                REG_REVERSE: rev_reg   <= cfg_wr_data[0];
                REG_MASKS:   masks_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Effective configuration: zero treated as one, base states and ring capped.
    logic [15:0]      p_eff;
    logic [3:0]       nb;
    logic [3:0]       e_eff;
    logic [7:0]       prod;
    logic [TOT_W-1:0] t_tot;

    always_comb begin
        p_eff = (ppr_reg == '0) ? 16'd1 : ppr_reg;
        nb    = (spe_reg == '0) ? 4'd1 : spe_reg;
        if (nb > 4'(MAX_BASE_STATES)) nb = 4'(MAX_BASE_STATES);
        e_eff = (epm_reg == '0) ? 4'd1 : epm_reg;
        prod  = 8'(nb) * 8'(e_eff);
        t_tot = (prod > 8'(TCAP)) ? TOT_W'(TCAP) : TOT_W'(prod);
    end

    function automatic logic [IW-1:0] neighbor(input logic [IW-1:0] idx,
                                               input logic [TOT_W-1:0] t,
                                               input logic rev);
        logic [8:0] i9, t9;
        i9 = 9'(idx);
        t9 = 9'(t);
        if (!rev) begin
            neighbor = (i9 + 9'd1 >= t9) ? '0 : IW'(i9 + 9'd1);
        end else begin
            neighbor = (i9 == '0 || i9 >= t9) ? IW'(t9 - 9'd1) : IW'(i9 - 9'd1);
        end
    endfunction

    // ---------------- sequencer registers ----------------
    seq_state_t                state_reg, state_next;
    logic [1:0]                op_reg, op_next;
    logic signed [POS_W-1:0]   pos_reg, pos_next;
    logic [IW-1:0]             cur_reg, cur_next;
    logic signed [POS_W-1:0]   held_low_reg, held_low_next;
    logic signed [POS_W-1:0]   held_high_reg, held_high_next;
    logic [16:0]               bw_reg, bw_next;      // base width
    logic [16:0]               se_reg, se_next;      // spread error
    logic [6:0]                sp_reg, sp_next;      // spread period
    logic [6:0]                sc_reg, sc_next;      // spread counter
    logic [6:0]                rr_reg, rr_next;      // width remainder
    logic [6:0]                ga_reg, ga_next, gb_reg, gb_next;
    logic                      ready_reg, ready_next;
    logic                      switched_reg, switched_next;
    logic [2:0]                base_reg, base_next;
    logic signed [WIDE_W-1:0]  v_reg, v_next;        // value to wrap
    logic signed [POS_W-1:0]   s_reg, s_next;        // running bound
    logic signed [POS_W-1:0]   wv_reg, wv_next;      // wrapped result
    logic [IW-1:0]             walk_reg, walk_next;
    logic [TOT_W-1:0]          k_reg, k_next;
    logic                      init_reg, init_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            held_low_reg  <= '0;
            held_high_reg <= '0;
            bw_reg        <= '0;
            se_reg        <= '0;
            sp_reg        <= 7'd1;
            sc_reg        <= '0;
            ready_reg     <= 1'b0;
            switched_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            held_low_reg  <= held_low_next;
            held_high_reg <= held_high_next;
            bw_reg        <= bw_next;
            se_reg        <= se_next;
            sp_reg        <= sp_next;
            sc_reg        <= sc_next;
            ready_reg     <= ready_next;
            switched_reg  <= switched_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        rr_reg   <= rr_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        base_reg <= base_next;
        v_reg    <= v_next;
        s_reg    <= s_next;
        wv_reg   <= wv_next;
        walk_reg <= walk_next;
        k_reg    <= k_next;
        init_reg <= init_next;
    end

    // ---------------- shared divider ----------------
    div_req_t div_req;
    div_rsp_t div_rsp;

    srmcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- interval table ----------------
    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    srmcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STATES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ---------------- wrap into the revolution ----------------
    // forward range [0, P], reverse range [-P, 0]; out-of-range values fold
    // through a modulo by P on the shared divider.
    logic signed [WIDE_W-1:0] pv, rem_s, wrap_res;
    logic                     wrap_need, low_side;
    logic [DVD_W-1:0]         wrap_dvd;

    always_comb begin
        pv    = $signed({4'b0, p_eff});
        rem_s = $signed({4'b0, div_rsp.remainder});
        if (!rev_reg) begin
            low_side  = v_reg < 0;
            wrap_need = low_side || (v_reg > pv);
            wrap_dvd  = low_side ? DVD_W'(~v_reg) : DVD_W'(v_reg);
            wrap_res  = low_side ? (pv - 20'sd1 - rem_s) : rem_s;
        end else begin
            low_side  = v_reg > 0;             // positive side in reverse
            wrap_need = low_side || (v_reg < -pv);
            wrap_dvd  = low_side ? DVD_W'(v_reg - 20'sd1) : DVD_W'(~v_reg);
            wrap_res  = low_side ? (rem_s + 20'sd1 - pv) : (-20'sd1 - rem_s);
        end
    end

    // spread counter step and next unwrapped bound
    logic [6:0]               sc_inc;
    logic                     sc_hit;
    logic [16:0]              change;
    logic signed [WIDE_W-1:0] s_wide, chg_wide;

    always_comb begin
        sc_inc   = sc_reg + 7'd1;
        sc_hit   = sc_inc == sp_reg;
        change   = sc_hit ? (bw_reg + se_reg) : bw_reg;
        s_wide   = WIDE_W'(s_reg);
        chg_wide = $signed({3'b0, change});
    end

    // store-phase bounds
    logic signed [POS_W-1:0] st_low, st_high;
    assign st_low  = rev_reg ? wv_reg : s_reg;
    assign st_high = rev_reg ? s_reg : wv_reg;

    // position test against held bounds
    logic in_lo, in_hi, in_range;
    assign in_lo    = held_low_reg <= pos_reg;
    assign in_hi    = held_high_reg >= pos_reg;
    assign in_range = ram_rdata[ENTRY_W-1] ? (in_lo || in_hi) : (in_lo && in_hi);

    // ---------------- next state and datapath ----------------
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        held_low_next  = held_low_reg;
        held_high_next = held_high_reg;
        bw_next        = bw_reg;
        se_next        = se_reg;
        sp_next        = sp_reg;
        sc_next        = sc_reg;
        rr_next        = rr_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        ready_next     = ready_reg;
        switched_next  = switched_reg;
        base_next      = base_reg;
        v_next         = v_reg;
        s_next         = s_reg;
        wv_next        = wv_reg;
        walk_next      = walk_reg;
        k_next         = k_reg;
        init_next      = init_reg;

        div_req.start    = 1'b0;
        div_req.dividend = DVD_W'(p_eff);
        div_req.divisor  = DVS_W'(t_tot);

        ram_we    = 1'b0;
        ram_waddr = walk_reg;
        ram_wdata = {st_low > st_high, st_high, st_low};
        ram_re    = 1'b0;
        ram_raddr = cur_reg;

        s_ready = 1'b0;
        m_valid = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next       = s_op;
                    pos_next      = s_position;
                    switched_next = 1'b0;
                    case (op_t'(s_op))
                        OP_STEP: begin
                            cur_next      = neighbor(cur_reg, t_tot, rev_reg);
                            switched_next = 1'b1;
                            state_next    = ST_BASE;
                        end
                        OP_BUILD: state_next = ST_WIDTH;
                        OP_POS:   state_next = ready_reg ? ST_READ : ST_BASE;
                        default:  state_next = ST_BASE;
                    endcase
                end
            end
            ST_WIDTH: begin                    // W = P / T, R = P mod T
                div_req.start = 1'b1;
                if (div_rsp.done) begin
                    bw_next    = div_rsp.quotient[16:0];
                    rr_next    = div_rsp.remainder[6:0];
                    ga_next    = 7'(t_tot);
                    gb_next    = div_rsp.remainder[6:0];
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin                      // Euclid on the divider
                div_req.dividend = DVD_W'(ga_reg);
                div_req.divisor  = DVS_W'(gb_reg);
                if (gb_reg == '0) begin
                    state_next = ST_ERR;
                end else begin
                    div_req.start = 1'b1;
                    if (div_rsp.done) begin
                        ga_next = gb_reg;
                        gb_next = div_rsp.remainder[6:0];
                    end
                end
            end
            ST_ERR: begin                      // spread error = R / g
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(rr_reg);
                div_req.divisor  = DVS_W'(ga_reg);
                if (div_rsp.done) begin
                    se_next    = div_rsp.quotient[16:0];
                    state_next = ST_PERIOD;
                end
            end
            ST_PERIOD: begin                   // spread period = T / g
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(t_tot);
                div_req.divisor  = DVS_W'(ga_reg);
                if (div_rsp.done) begin
                    sp_next    = div_rsp.quotient[6:0];
                    sc_next    = '0;
                    walk_next  = neighbor(cur_reg, t_tot, rev_reg);
                    k_next     = '0;
                    init_next  = 1'b1;
                    v_next     = rev_reg ? (WIDE_W'(pos_reg) - WIDE_W'(off_reg))
                                         : (WIDE_W'(pos_reg) + WIDE_W'(off_reg));
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                div_req.dividend = wrap_dvd;
                div_req.divisor  = DVS_W'(p_eff);
                if (!wrap_need) begin
                    wv_next = POS_W'(v_reg);
                    if (init_reg) begin
                        s_next     = POS_W'(v_reg);
                        init_next  = 1'b0;
                        state_next = ST_CHANGE;
                    end else begin
                        state_next = ST_STORE;
                    end
                end else begin
                    div_req.start = 1'b1;
                    if (div_rsp.done) begin
                        wv_next = POS_W'(wrap_res);
                        if (init_reg) begin
                            s_next     = POS_W'(wrap_res);
                            init_next  = 1'b0;
                            state_next = ST_CHANGE;
                        end else begin
                            state_next = ST_STORE;
                        end
                    end
                end
            end
            ST_CHANGE: begin
                sc_next    = sc_hit ? '0 : sc_inc;
                v_next     = rev_reg ? (s_wide - chg_wide) : (s_wide + chg_wide);
                state_next = ST_WRAP;
            end
            ST_STORE: begin
                ram_we = 1'b1;
                if (k_reg == '0) begin
                    held_low_next  = st_low;
                    held_high_next = st_high;
                end
                s_next    = wv_reg;
                walk_next = neighbor(walk_reg, t_tot, rev_reg);
                k_next    = k_reg + 1'b1;
                if (k_reg + 1'b1 == t_tot) begin
                    ready_next = 1'b1;
                    state_next = ST_BASE;
                end else begin
                    state_next = ST_CHANGE;
                end
            end
            ST_READ: begin                     // fetch wrap flag of current state
                ram_re     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                ram_re    = 1'b1;
                ram_raddr = neighbor(cur_reg, t_tot, rev_reg);
                if (!in_range) begin
                    cur_next      = neighbor(cur_reg, t_tot, rev_reg);
                    switched_next = 1'b1;
                    state_next    = ST_LOAD;
                end else begin
                    state_next = ST_BASE;
                end
            end
            ST_LOAD: begin
                held_low_next  = ram_rdata[POS_W-1:0];
                held_high_next = ram_rdata[2*POS_W-1:POS_W];
                state_next     = ST_BASE;
            end
            ST_BASE: begin                     // base state = index mod n
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(cur_reg);
                div_req.divisor  = DVS_W'(nb);
                if (div_rsp.done) begin
                    base_next  = div_rsp.remainder[2:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result fields; the user must keep config stable while a result waits; the block does not enforce it.
    assign m_switch_mask = masks_reg[8*base_reg +: 8] & SW_MASK;
    assign m_state_index = 6'(cur_reg);
    assign m_switched    = switched_reg;
    assign m_table_ready = ready_reg;

endmodule
